// File: src/efba_pkg.sv
// Package for the exact-fit block allocator: payload structs, status codes,
// operation kinds and sizing constants. No dependencies.
package efba_pkg;

  localparam int unsigned MaxBlocksDef  = 64;
  localparam int unsigned AlignBytesDef = 256;
  localparam int unsigned DescBytesDef  = 24;
  localparam int unsigned QueueDepth    = 2;

  typedef enum logic [0:0] {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_NEW        = 3'd0,
    ST_REUSED     = 3'd1,
    ST_FREED      = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_TABLE_FULL = 3'd4,
    ST_EXHAUSTED  = 3'd5
  } status_e;

  typedef struct packed {
    logic        kind;
    logic [31:0] request_size;
    logic [31:0] block_address;
  } req_t;

  typedef struct packed {
    logic [31:0] granted_address;
    logic [2:0]  status;
  } rsp_t;

  // Classified command handed from the front end to the engine
  typedef struct packed {
    logic        is_free;
    logic        size_ovf;   // rounded size does not fit 32 bits
    logic [31:0] aligned;    // rounded size (valid if !size_ovf)
    logic [31:0] address;
  } cmd_t;

  typedef enum logic [1:0] {
    EN_IDLE,
    EN_SCAN,
    EN_FINISH,
    EN_OUT
  } eng_state_e;

endpackage

// File: src/efba_front.sv
// Front end: accepts requests, rounds the size and queues the classified
// command for the engine. Depends on efba_pkg.
module efba_front #(
  parameter int unsigned ALIGN_BYTES = efba_pkg::AlignBytesDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid,
  output logic          in_stall,
  input  efba_pkg::req_t in_data_i,
  output logic          cmd_valid_o,
  input  logic          cmd_take_i,
  output efba_pkg::cmd_t cmd_o
);

  localparam int unsigned Depth = efba_pkg::QueueDepth;

  efba_pkg::cmd_t       queue_q [Depth];
  logic                 wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]           count_q, count_d;
  logic                 push, pop;
  logic [32:0]          grown, aligned;
  efba_pkg::cmd_t       cmd_new;

  // Round up to the next multiple, always adding one step
  always_comb begin
    grown   = {1'b0, in_data_i.request_size} + 33'(ALIGN_BYTES);
    aligned = grown - (grown % 33'(ALIGN_BYTES));
    cmd_new.is_free  = (in_data_i.kind == efba_pkg::KIND_FREE);
    cmd_new.size_ovf = aligned[32];
    cmd_new.aligned  = aligned[31:0];
    cmd_new.address  = in_data_i.block_address;
  end

  assign in_stall    = (count_q == 2'(Depth));
  assign push        = in_valid && !in_stall;
  assign cmd_valid_o = (count_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_take_i;
  assign cmd_o       = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

  // Queue never overflows or underflows
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= 2'(Depth))
    else $error("command queue overfilled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0) |-> !pop) else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 2'd1))
    else $error("queue count lost a push");

endmodule

// File: src/efba_engine.sv
// Engine: descriptor table and scan sequencer, one entry per cycle, plus
// the result register. Depends on efba_pkg.
module efba_engine #(
  parameter int unsigned MAX_BLOCKS = efba_pkg::MaxBlocksDef,
  parameter int unsigned DESC_BYTES = efba_pkg::DescBytesDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [31:0]    heap_start_i,
  input  logic           cmd_valid_i,
  output logic           cmd_take_o,
  input  efba_pkg::cmd_t cmd_i,
  output logic           out_valid,
  input  logic           out_stall,
  output efba_pkg::rsp_t out_data_o
);

  localparam int unsigned IdxW = $clog2(MAX_BLOCKS);
  localparam int unsigned CntW = $clog2(MAX_BLOCKS + 1);

  // Descriptor storage: one read port, read data registered
  logic [31:0] mem_addr_q [MAX_BLOCKS];
  logic [31:0] mem_size_q [MAX_BLOCKS];
  logic [31:0] mem_order_q [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] in_use_q, is_free_q;

  efba_pkg::eng_state_e state_q, state_d;
  efba_pkg::cmd_t       cmd_q;
  logic [CntW-1:0]      scan_q, scan_d;       // address presented to memory
  logic                 rd_vld_q;
  logic [IdxW-1:0]      rd_idx_q;
  logic [31:0]          rd_addr_q, rd_size_q, rd_order_q;
  logic                 best_vld_q;
  logic [IdxW-1:0]      best_idx_q;
  logic [31:0]          best_age_q, best_addr_q;
  logic [31:0]          free_seq_q;
  logic [CntW-1:0]      count_q;
  logic [32:0]          brk_q;
  efba_pkg::rsp_t       rsp_q;
  logic                 scan_done;
  logic                 hit_alloc, hit_free;
  logic [31:0]          age;
  logic [33:0]          addr_w, next_w;
  logic                 wr_new;
  logic                 finishing;

  // ---- next state
  assign scan_done = (scan_q == CntW'(MAX_BLOCKS));
  always_comb begin
    state_d = state_q;
    case (state_q)
      efba_pkg::EN_IDLE:   if (cmd_valid_i) state_d = efba_pkg::EN_SCAN;
      efba_pkg::EN_SCAN:   if (scan_done && !rd_vld_q) state_d = efba_pkg::EN_FINISH;
      efba_pkg::EN_FINISH: state_d = efba_pkg::EN_OUT;
      efba_pkg::EN_OUT:    if (!out_stall) state_d = efba_pkg::EN_IDLE;
      default:             state_d = efba_pkg::EN_IDLE;
    endcase
  end

  // ---- outputs
  always_comb begin
    cmd_take_o = 1'b0;
    out_valid  = 1'b0;
    finishing  = 1'b0;
    case (state_q)
      efba_pkg::EN_IDLE:   cmd_take_o = cmd_valid_i;
      efba_pkg::EN_FINISH: finishing  = 1'b1;
      efba_pkg::EN_OUT:    out_valid  = 1'b1;
      default:             ;
    endcase
  end
  assign out_data_o = rsp_q;

  // Match on the registered read
  assign age       = free_seq_q - rd_order_q;
  assign hit_alloc = rd_vld_q && !cmd_q.is_free && in_use_q[rd_idx_q] &&
                     is_free_q[rd_idx_q] && !cmd_q.size_ovf &&
                     (rd_size_q == cmd_q.aligned);
  assign hit_free  = rd_vld_q && cmd_q.is_free && in_use_q[rd_idx_q] &&
                     !is_free_q[rd_idx_q] && (rd_addr_q == cmd_q.address);

  // New block geometry
  assign addr_w = 34'(heap_start_i) + 34'(brk_q) + 34'(DESC_BYTES);
  assign next_w = addr_w + 34'(cmd_q.aligned);
  assign wr_new = finishing && !cmd_q.is_free && !best_vld_q &&
                  (count_q != CntW'(MAX_BLOCKS)) && !cmd_q.size_ovf &&
                  (next_w <= 34'h1_0000_0000);

  always_comb begin
    scan_d = scan_q;
    if (state_q == efba_pkg::EN_IDLE) scan_d = '0;
    else if (state_q == efba_pkg::EN_SCAN && !scan_done) scan_d = scan_q + 1'b1;
  end

  // Memory: new entries and free stamps written, scan reads
  always_ff @(posedge clk_i) begin
    if (wr_new) begin
      mem_addr_q[count_q[IdxW-1:0]] <= addr_w[31:0];
      mem_size_q[count_q[IdxW-1:0]] <= cmd_q.aligned;
    end
    if (finishing && best_vld_q && cmd_q.is_free) begin
      mem_order_q[best_idx_q] <= free_seq_q;
    end
    rd_addr_q  <= mem_addr_q[scan_q[IdxW-1:0]];
    rd_size_q  <= mem_size_q[scan_q[IdxW-1:0]];
    rd_order_q <= mem_order_q[scan_q[IdxW-1:0]];
    rd_idx_q   <= scan_q[IdxW-1:0];
    if (cmd_take_o) cmd_q <= cmd_i;
  end

  // Control and bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= efba_pkg::EN_IDLE;
      scan_q     <= '0;
      rd_vld_q   <= 1'b0;
      best_vld_q <= 1'b0;
      best_idx_q <= '0;
      best_age_q <= '0;
      best_addr_q <= '0;
      free_seq_q <= '0;
      count_q    <= '0;
      brk_q      <= '0;
      in_use_q   <= '0;
      is_free_q  <= '0;
      rsp_q      <= '0;
    end else begin
      state_q  <= state_d;
      scan_q   <= scan_d;
      rd_vld_q <= (state_q == efba_pkg::EN_SCAN) && !scan_done &&
                  (scan_q < count_q);
      if (state_q == efba_pkg::EN_IDLE) begin
        best_vld_q <= 1'b0;
      end else if (hit_alloc && (!best_vld_q || age < best_age_q)) begin
        best_vld_q  <= 1'b1;
        best_idx_q  <= rd_idx_q;
        best_age_q  <= age;
        best_addr_q <= rd_addr_q;
      end else if (hit_free && !best_vld_q) begin
        best_vld_q <= 1'b1;
        best_idx_q <= rd_idx_q;
      end
      if (finishing) begin
        if (cmd_q.is_free) begin
          rsp_q.granted_address <= '0;
          if (best_vld_q) begin
            is_free_q[best_idx_q] <= 1'b1;
            free_seq_q <= free_seq_q + 32'd1;
            rsp_q.status <= efba_pkg::ST_FREED;
          end else begin
            rsp_q.status <= efba_pkg::ST_NOT_FOUND;
          end
        end else if (best_vld_q) begin
          is_free_q[best_idx_q] <= 1'b0;
          rsp_q.granted_address <= best_addr_q;
          rsp_q.status <= efba_pkg::ST_REUSED;
        end else if (count_q == CntW'(MAX_BLOCKS)) begin
          rsp_q <= '{32'd0, efba_pkg::ST_TABLE_FULL};
        end else if (!wr_new) begin
          rsp_q <= '{32'd0, efba_pkg::ST_EXHAUSTED};
        end else begin
          in_use_q[count_q[IdxW-1:0]]  <= 1'b1;
          is_free_q[count_q[IdxW-1:0]] <= 1'b0;
          count_q <= count_q + 1'b1;
          brk_q   <= brk_q + 33'(DESC_BYTES) + 33'(cmd_q.aligned);
          rsp_q   <= '{addr_w[31:0], efba_pkg::ST_NEW};
        end
      end
    end
  end

  // Entry count never passes the table size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_BLOCKS)) else $error("entry count overflow");
  // A new entry is only written while the table has room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_new |-> (count_q < CntW'(MAX_BLOCKS))) else $error("write past table");
  // Only valid results leave the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (rsp_q.status <= efba_pkg::ST_EXHAUSTED))
    else $error("bad status code");
  // Free slots are always in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((is_free_q & ~in_use_q) == '0)) else $error("free bit on unused slot");

endmodule

// File: src/exact_fit_block_allocator_top.sv
// Top level of the exact-fit block allocator: configuration register,
// front end and engine. Depends on efba_pkg, efba_front, efba_engine.
//
// Usage: requests arrive on in_valid/in_stall with payload in_data_i
// (kind, request_size, block_address). One result per request leaves on
// out_valid/out_stall with out_data_o (granted_address, status). A
// transfer happens at a clock edge where valid is high and stall is low.
// The user writes heap_start through cfg_we_i/cfg_data_i only while idle;
// the block itself does not enforce this. The engine handles one request
// at a time, scanning the descriptor table one entry a cycle through its
// single read port, and takes the next command only after the result has
// left. A result is ready once the whole table has been scanned, after any
// wait behind a request already in the engine. A two-entry command queue
// lets the front accept while the engine works. If the receiver stalls,
// the result holds in the output register and the engine waits; the queue
// keeps taking requests until full. Reset empties the queue, clears the
// table's in-use and free bits, the break and the free stamp; heap_start
// resets to zero.
module exact_fit_block_allocator_top #(
  parameter int unsigned MAX_BLOCKS  = efba_pkg::MaxBlocksDef,
  parameter int unsigned ALIGN_BYTES = efba_pkg::AlignBytesDef,
  parameter int unsigned DESC_BYTES  = efba_pkg::DescBytesDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [31:0]    cfg_data_i,
  input  logic           in_valid,
  output logic           in_stall,
  input  efba_pkg::req_t in_data_i,
  output logic           out_valid,
  input  logic           out_stall,
  output efba_pkg::rsp_t out_data_o
);

  logic [31:0]    heap_start_q;
  logic           cmd_valid, cmd_take;
  efba_pkg::cmd_t cmd;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) heap_start_q <= '0;
    else if (cfg_we_i) heap_start_q <= cfg_data_i;
  end

  efba_front #(.ALIGN_BYTES(ALIGN_BYTES)) u_front (
    .clk_i, .rst_ni, .in_valid, .in_stall, .in_data_i,
    .cmd_valid_o(cmd_valid), .cmd_take_i(cmd_take), .cmd_o(cmd)
  );

  efba_engine #(.MAX_BLOCKS(MAX_BLOCKS), .DESC_BYTES(DESC_BYTES)) u_engine (
    .clk_i, .rst_ni, .heap_start_i(heap_start_q),
    .cmd_valid_i(cmd_valid), .cmd_take_o(cmd_take), .cmd_i(cmd),
    .out_valid, .out_stall, .out_data_o
  );

endmodule

// File: tb/tb_exact_fit_block_allocator_top.sv
// Testbench for exact_fit_block_allocator_top. It uses a built-in heap model
// that is updated on every accepted request, under random sender/receiver idling.
// Depends on efba_pkg and the allocator RTL only.
module tb_exact_fit_block_allocator_top;

  localparam int unsigned NumSlots  = 64;
  localparam int unsigned Align     = 256;
  localparam int unsigned DescBytes = 24;
  localparam int unsigned DrainWait = 80;

  // Heap model plus the queue of results still owed by the block
  class heap_scoreboard;
    logic [31:0]    heap_start;
    logic [31:0]    slot_addr [NumSlots];
    logic [31:0]    slot_size [NumSlots];
    bit             slot_used [NumSlots];
    bit             slot_freed[NumSlots];
    logic [31:0]    slot_stamp[NumSlots];
    logic [31:0]    free_stamp;
    int unsigned    slot_count;
    logic [32:0]    brk;
    efba_pkg::rsp_t owed[$];
    int unsigned    errors;

    function void clear();
      heap_start = '0;
      free_stamp = '0;
      slot_count = 0;
      brk = '0;
      errors = 0;
      foreach (slot_used[i]) begin
        slot_used[i] = 0;
        slot_freed[i] = 0;
      end
    endfunction

    function efba_pkg::rsp_t allocate(logic [31:0] size);
      efba_pkg::rsp_t r;
      longint unsigned rounded, base, addr, next_brk;
      int best;
      logic [31:0] best_age, age;
      rounded = longint'(size) + Align;
      rounded = rounded - (rounded % Align);
      best = -1;
      best_age = '0;
      r = '0;
      // most recently freed block of exactly this size
      for (int i = 0; i < NumSlots; i++) begin
        if (slot_used[i] && slot_freed[i] && longint'(slot_size[i]) == rounded) begin
          age = free_stamp - slot_stamp[i];
          if (best < 0 || age < best_age) begin
            best = i;
            best_age = age;
          end
        end
      end
      if (best >= 0) begin
        slot_freed[best] = 0;
        r.granted_address = slot_addr[best];
        r.status = efba_pkg::ST_REUSED;
        return r;
      end
      if (slot_count >= NumSlots) begin
        r.status = efba_pkg::ST_TABLE_FULL;
        return r;
      end
      base = longint'(heap_start) + longint'(brk);
      addr = base + DescBytes;
      next_brk = addr + rounded;
      if (rounded > 64'hFFFF_FFFF || next_brk > 64'h1_0000_0000) begin
        r.status = efba_pkg::ST_EXHAUSTED;
        return r;
      end
      slot_addr[slot_count] = addr[31:0];
      slot_size[slot_count] = rounded[31:0];
      slot_used[slot_count] = 1;
      slot_freed[slot_count] = 0;
      slot_count++;
      brk = brk + DescBytes + rounded[32:0];
      r.granted_address = addr[31:0];
      r.status = efba_pkg::ST_NEW;
      return r;
    endfunction

    function efba_pkg::rsp_t release_block(logic [31:0] addr);
      efba_pkg::rsp_t r;
      r = '0;
      r.status = efba_pkg::ST_NOT_FOUND;
      for (int i = 0; i < NumSlots; i++) begin
        if (slot_used[i] && !slot_freed[i] && slot_addr[i] == addr) begin
          slot_freed[i] = 1;
          slot_stamp[i] = free_stamp;
          free_stamp++;
          r.status = efba_pkg::ST_FREED;
          return r;
        end
      end
      return r;
    endfunction

    // accepted request: work out the result it owes
    function void note_request(efba_pkg::req_t q);
      if (q.kind == efba_pkg::KIND_FREE) owed.push_back(release_block(q.block_address));
      else owed.push_back(allocate(q.request_size));
    endfunction

    // accepted result: compare with the oldest owed one
    function void check_result(efba_pkg::rsp_t got);
      efba_pkg::rsp_t want;
      if (owed.size() == 0) begin
        $error("unexpected result: addr %h status %0d", got.granted_address, got.status);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.granted_address !== want.granted_address) begin
        $error("granted_address: expected %h, got %h", want.granted_address,
               got.granted_address);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic           clk_i;
  logic           rst_ni;
  logic           cfg_we_i;
  logic [31:0]    cfg_data_i;
  logic           in_valid;
  logic           in_stall;
  efba_pkg::req_t in_data_i;
  logic           out_valid;
  logic           out_stall;
  efba_pkg::rsp_t out_data_o;

  heap_scoreboard heap;
  int unsigned    stall_pct;
  bit             long_hold;

  exact_fit_block_allocator_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data_i  (in_data_i),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data_o (out_data_o)
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // transfer monitors
  always @(posedge clk_i) begin
    if (rst_ni && in_valid && !in_stall) heap.note_request(in_data_i);
    if (rst_ni && out_valid && !out_stall) heap.check_result(out_data_o);
  end

  // receiver stall pattern, with a long hold-off when long_hold is set
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (700) @(posedge clk_i);
        out_stall <= 1'b0;
        long_hold = 0;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  int unsigned burst_left;

  task automatic send(input efba_pkg::req_t q);
    bit stalled;
    in_valid  <= 1'b1;
    in_data_i <= q;
    do begin
      @(negedge clk_i);
      stalled = in_stall;
      @(posedge clk_i);
    end while (stalled);
    if (burst_left == 0) begin
      burst_left = $urandom_range(12);
      if ($urandom_range(3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 90)) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_alloc(input logic [31:0] size);
    efba_pkg::req_t q;
    q.kind = efba_pkg::KIND_ALLOC;
    q.request_size = size;
    q.block_address = $urandom();
    send(q);
  endtask

  task automatic send_free(input logic [31:0] addr);
    efba_pkg::req_t q;
    q.kind = efba_pkg::KIND_FREE;
    q.request_size = $urandom();
    q.block_address = addr;
    send(q);
  endtask

  // wait until every owed result is back, then let the engine settle
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (heap.owed.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic set_heap_start(input logic [31:0] v);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    heap.heap_start = v;
  endtask

  task automatic random_request();
    logic [31:0] size;
    if ($urandom_range(99) < 55) begin
      case ($urandom_range(5))
        0: size = $urandom();
        1: size = $urandom_range(0, 255);
        default: size = 256 * $urandom_range(0, 5) + $urandom_range(0, 1) * 255;
      endcase
      send_alloc(size);
    end else if (heap.slot_count != 0 && $urandom_range(9) < 8) begin
      send_free(heap.slot_addr[$urandom_range(heap.slot_count - 1)]);
    end else begin
      send_free($urandom());
    end
  endtask

  initial begin
    heap = new();
    heap.clear();
    burst_left = 0;
    stall_pct = 0;
    long_hold = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    in_valid = 1'b0;
    in_data_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: rounding, exhaustion, free misses, reuse order
    set_heap_start(32'h0);
    stall_pct = 20;
    send_alloc(32'h0);
    send_alloc(32'd255);
    send_alloc(32'd256);
    send_alloc(32'hFFFF_FF00);
    send_alloc(32'hFFFF_FFFF);
    send_free(32'd24);
    send_free(32'd24);
    send_free(32'h0);
    send_free(32'd304);
    send_alloc(32'd1);
    send_alloc(32'd1);
    send_alloc(32'd1);
    send_free(32'hFFFF_FFFF);
    set_heap_start(32'hFFFF_FF00);
    send_alloc(32'h0);
    send_free(32'd584);
    send_alloc(32'd300);
    set_heap_start(32'hFFFF_FFFF);
    send_alloc(32'h0);
    send_alloc(32'd700);

    // random traffic, with a long receiver hold-off in the middle
    set_heap_start(32'h0001_0000);
    for (int n = 0; n < 500; n++) begin
      if (n == 150) begin
        stall_pct = 0;
        long_hold = 1;
      end
      if (n == 250) drain();
      if (n == 300) stall_pct = 60;
      if (n == 400) stall_pct = 10;
      random_request();
    end
    drain();
    if (heap.errors == 0) begin
      $display("** exact_fit_block_allocator_top: PASSED **");
    end else begin
      $display("** exact_fit_block_allocator_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("** exact_fit_block_allocator_top: FAILED **");
    $finish;
  end

endmodule
